### hdl/point_fov_range_filter_core_defines.svh
// Assertion macros for the point FOV and range filter.
// No dependencies; included by the modules that carry assertions.
`ifndef POINT_FOV_RANGE_FILTER_CORE_DEFINES_SVH
`define POINT_FOV_RANGE_FILTER_CORE_DEFINES_SVH

// same-cycle implication
`define PFR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/pfr_pkg.sv
// Shared widths, register codes, reset values and types of the point filter.
// No dependencies.
package pfr_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int COORD_FRAC_BITS = 10;
    localparam int ROT_FRAC_BITS   = 14;

    localparam int ROT_ENTRY_W   = 16;
    localparam int ROT_ROW_W     = 3 * ROT_ENTRY_W;
    localparam int TAN_W         = 24;
    localparam int TAN_FRAC_BITS = 16;
    localparam int DIST_W        = 48;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;

    localparam int DIFF_W   = COORD_WIDTH + 1;
    localparam int PROD_W   = DIFF_W + ROT_ENTRY_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int BODY_W   = SUM_W - ROT_FRAC_BITS;
    localparam int SQ_IN_W  = DIST_W / 2;
    localparam int EXT_W    = ((BODY_W > SQ_IN_W) ? BODY_W : SQ_IN_W) + 1;
    localparam int SQ_W     = 2 * SQ_IN_W;
    localparam int SQ_SUM_W = SQ_W + 2;
    localparam int CONE_W   = BODY_W + TAN_W;

    // 0.001 m on the coordinate grid, never below one LSB
    localparam int DEPTH_MIN_RAW = ((1 << COORD_FRAC_BITS) + 500) / 1000;
    localparam int DEPTH_MIN     = (DEPTH_MIN_RAW < 1) ? 1 : DEPTH_MIN_RAW;
    localparam logic signed [BODY_W-1:0] DEPTH_MIN_BODY = BODY_W'(DEPTH_MIN);

    localparam logic [CFG_IDX_W-1:0] CFG_POS_X    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Z    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW0 = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW1 = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW2 = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_TAN      = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = CFG_IDX_W'(7);

    localparam logic [ROT_ROW_W-1:0] ROT_ROW0_RST = ROT_ROW_W'(1) << ROT_FRAC_BITS;
    localparam logic [ROT_ROW_W-1:0] ROT_ROW1_RST =
        ROT_ROW_W'(1) << (ROT_FRAC_BITS + ROT_ENTRY_W);
    localparam logic [ROT_ROW_W-1:0] ROT_ROW2_RST =
        ROT_ROW_W'(1) << (ROT_FRAC_BITS + 2 * ROT_ENTRY_W);
    localparam logic [TAN_W-1:0]     TAN_RST      = TAN_W'(1) << TAN_FRAC_BITS;
    localparam logic [TAN_W-1:0]     TAN_ALL_ONES = '1;
    localparam logic [DIST_W-1:0]    DIST_RST     = DIST_W'(64'd2621440000);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
        logic                          last;
    } t_point;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic signed [COORD_WIDTH-1:0] pos_z;
        logic [2:0][ROT_ROW_W-1:0]     rot;
        logic [TAN_W-1:0]              tan_limit;
        logic [DIST_W-1:0]             max_dist_sq;
    } t_cfg;

    function automatic logic signed [ROT_ENTRY_W-1:0] rot_entry(
        input logic [ROT_ROW_W-1:0] row,
        input int unsigned          k
    );
        return row[k*ROT_ENTRY_W +: ROT_ENTRY_W];
    endfunction

endpackage

### hdl/point_fov_range_filter_core.sv
// Channel   Handshake                  Payload
// cfg       i_cfg_valid/o_cfg_ready    i_cfg_index, i_cfg_data
// point in  i_valid/o_ready            i_world_x/y/z, i_frame_last
// point out o_valid/i_ready            o_out_x/y/z, o_keep, o_out_last
//
// One request per cycle sustained while i_ready is high. Register stages: offset,
// products, row sums, test products, decision. Reset clears the stage valid bits
// and loads the default configuration. Each stage holds its request while the next
// is full and blocked; empty stages still take new requests, so bubbles close up.
// Depends on pfr_pkg, pfr_cfg_regs, pfr_xform and pfr_test.
module point_fov_range_filter_core import pfr_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_world_x,
    input  logic signed [COORD_WIDTH-1:0] i_world_y,
    input  logic signed [COORD_WIDTH-1:0] i_world_z,
    input  logic                          i_frame_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic signed [COORD_WIDTH-1:0] o_out_z,
    output logic                          o_keep,
    output logic                          o_out_last
);

    t_cfg   cfg;
    t_point in_point, mid_point, out_point;
    logic   mid_valid, mid_ready;
    logic signed [BODY_W-1:0] body_x, body_y, body_z;

    assign in_point.x    = i_world_x;
    assign in_point.y    = i_world_y;
    assign in_point.z    = i_world_z;
    assign in_point.last = i_frame_last;

    pfr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pfr_xform u_xform (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_point  (in_point),
        .i_cfg    (cfg),
        .o_valid  (mid_valid),
        .i_ready  (mid_ready),
        .o_point  (mid_point),
        .o_body_x (body_x),
        .o_body_y (body_y),
        .o_body_z (body_z)
    );

    pfr_test u_test (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (mid_valid),
        .o_ready  (mid_ready),
        .i_point  (mid_point),
        .i_body_x (body_x),
        .i_body_y (body_y),
        .i_body_z (body_z),
        .i_cfg    (cfg),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_point  (out_point),
        .o_keep   (o_keep)
    );

    assign o_out_x    = out_point.x;
    assign o_out_y    = out_point.y;
    assign o_out_z    = out_point.z;
    assign o_out_last = out_point.last;

endmodule

### hdl/pfr_cfg_regs.sv
// Configuration register file of the point filter: position, rotation, limits.
// Depends on pfr_pkg.
module pfr_cfg_regs import pfr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_x       <= '0;
            r_cfg.pos_y       <= '0;
            r_cfg.pos_z       <= '0;
            r_cfg.rot[0]      <= ROT_ROW0_RST;
            r_cfg.rot[1]      <= ROT_ROW1_RST;
            r_cfg.rot[2]      <= ROT_ROW2_RST;
            r_cfg.tan_limit   <= TAN_RST;
            r_cfg.max_dist_sq <= DIST_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_POS_X:    r_cfg.pos_x       <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_POS_Y:    r_cfg.pos_y       <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_POS_Z:    r_cfg.pos_z       <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_ROT_ROW0: r_cfg.rot[0]      <= i_cfg_data[ROT_ROW_W-1:0];
                CFG_ROT_ROW1: r_cfg.rot[1]      <= i_cfg_data[ROT_ROW_W-1:0];
                CFG_ROT_ROW2: r_cfg.rot[2]      <= i_cfg_data[ROT_ROW_W-1:0];
                CFG_TAN:      r_cfg.tan_limit   <= i_cfg_data[TAN_W-1:0];
                CFG_MAX_DIST: r_cfg.max_dist_sq <= i_cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

### hdl/pfr_xform.sv
// World-to-body transform: offset, nine products, row sums floored to the grid.
// Three register stages; depends on pfr_pkg.
module pfr_xform import pfr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_point                   i_point,
    input  t_cfg                     i_cfg,
    output logic                     o_valid,
    input  logic                     i_ready,
    output t_point                   o_point,
    output logic signed [BODY_W-1:0] o_body_x,
    output logic signed [BODY_W-1:0] o_body_y,
    output logic signed [BODY_W-1:0] o_body_z
);

    logic take1, take2, take3;
    logic r_v1, r_v2, r_v3;
    t_point r_p1, r_p2, r_p3;

    logic signed [DIFF_W-1:0] n_d  [3];
    logic signed [DIFF_W-1:0] r_d1 [3];
    logic signed [PROD_W-1:0] n_prod  [3][3];
    logic signed [PROD_W-1:0] r_prod2 [3][3];
    logic signed [SUM_W-1:0]  n_sum  [3];
    logic signed [BODY_W-1:0] n_body [3];
    logic signed [BODY_W-1:0] r_body3 [3];

    assign take3   = !r_v3 || i_ready;
    assign take2   = !r_v2 || take3;
    assign take1   = !r_v1 || take2;
    assign o_ready = take1;

    always_comb begin
        n_d[0] = {i_point.x[COORD_WIDTH-1], i_point.x}
               - {i_cfg.pos_x[COORD_WIDTH-1], i_cfg.pos_x};
        n_d[1] = {i_point.y[COORD_WIDTH-1], i_point.y}
               - {i_cfg.pos_y[COORD_WIDTH-1], i_cfg.pos_y};
        n_d[2] = {i_point.z[COORD_WIDTH-1], i_point.z}
               - {i_cfg.pos_z[COORD_WIDTH-1], i_cfg.pos_z};
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_prod[r][c] = rot_entry(i_cfg.rot[r], c) * r_d1[c];
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_sum[r]  = SUM_W'(r_prod2[r][0]) + SUM_W'(r_prod2[r][1])
                      + SUM_W'(r_prod2[r][2]);
            n_body[r] = n_sum[r][SUM_W-1:ROT_FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (take1) r_v1 <= i_valid;
            if (take2) r_v2 <= r_v1;
            if (take3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take1) begin
            r_p1 <= i_point;
            r_d1 <= n_d;
        end
        if (take2) begin
            r_p2    <= r_p1;
            r_prod2 <= n_prod;
        end
        if (take3) begin
            r_p3    <= r_p2;
            r_body3 <= n_body;
        end
    end

    assign o_valid  = r_v3;
    assign o_point  = r_p3;
    assign o_body_x = r_body3[0];
    assign o_body_y = r_body3[1];
    assign o_body_z = r_body3[2];

endmodule

### hdl/pfr_test.sv
// Depth, cone and range tests on body coordinates; products, then the keep decision.
// Two register stages; depends on pfr_pkg and the assertion macros.
`include "point_fov_range_filter_core_defines.svh"
module pfr_test import pfr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_point                   i_point,
    input  logic signed [BODY_W-1:0] i_body_x,
    input  logic signed [BODY_W-1:0] i_body_y,
    input  logic signed [BODY_W-1:0] i_body_z,
    input  t_cfg                     i_cfg,
    output logic                     o_valid,
    input  logic                     i_ready,
    output t_point                   o_point,
    output logic                     o_keep
);

    function automatic logic [EXT_W-1:0] mag_ext(input logic signed [BODY_W-1:0] v);
        logic signed [EXT_W-1:0] e;
        e = EXT_W'(v);
        return v[BODY_W-1] ? -e : e;
    endfunction

    logic take4, take5;
    logic r_v4, r_v5;
    t_point r_p4, r_p5;

    logic [EXT_W-1:0]   n_ax, n_ay, n_az;
    logic               n_depth, n_big;
    logic [CONE_W-1:0]  n_lhs, n_rhs;
    logic [SQ_W-1:0]    n_sq [3];
    logic [SQ_SUM_W-1:0] n_sq_sum;
    logic               n_keep;

    logic               r_depth4, r_big4, r_tan_all4;
    logic [CONE_W-1:0]  r_lhs4, r_rhs4;
    logic [SQ_W-1:0]    r_sq4 [3];
    logic               r_keep5;

    assign take5   = !r_v5 || i_ready;
    assign take4   = !r_v4 || take5;
    assign o_ready = take4;

    always_comb begin
        n_ax    = mag_ext(i_body_x);
        n_ay    = mag_ext(i_body_y);
        n_az    = mag_ext(i_body_z);
        n_depth = i_body_x >= DEPTH_MIN_BODY;
        n_big   = (|n_ax[EXT_W-1:SQ_IN_W]) || (|n_ay[EXT_W-1:SQ_IN_W])
               || (|n_az[EXT_W-1:SQ_IN_W]);
        n_lhs   = CONE_W'(n_ay) << TAN_FRAC_BITS;
        n_rhs   = i_body_x[BODY_W-2:0] * i_cfg.tan_limit;
        n_sq[0] = n_ax[SQ_IN_W-1:0] * n_ax[SQ_IN_W-1:0];
        n_sq[1] = n_ay[SQ_IN_W-1:0] * n_ay[SQ_IN_W-1:0];
        n_sq[2] = n_az[SQ_IN_W-1:0] * n_az[SQ_IN_W-1:0];
    end

    always_comb begin
        n_sq_sum = SQ_SUM_W'(r_sq4[0]) + SQ_SUM_W'(r_sq4[1]) + SQ_SUM_W'(r_sq4[2]);
        n_keep   = r_depth4 && !r_big4 && (r_tan_all4 || (r_lhs4 <= r_rhs4))
                && (n_sq_sum <= SQ_SUM_W'(i_cfg.max_dist_sq));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (take4) r_v4 <= i_valid;
            if (take5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take4) begin
            r_p4       <= i_point;
            r_depth4   <= n_depth;
            r_big4     <= n_big;
            r_tan_all4 <= i_cfg.tan_limit == TAN_ALL_ONES;
            r_lhs4     <= n_lhs;
            r_rhs4     <= n_rhs;
            r_sq4      <= n_sq;
        end
        if (take5) begin
            r_p5    <= r_p4;
            r_keep5 <= n_keep;
        end
    end

    assign o_valid = r_v5;
    assign o_point = r_p5;
    assign o_keep  = r_keep5;

    `PFR_ASSERT_NXT(a_shallow_dropped, i_clk, i_rst_n, r_v4 && take5 && !r_depth4, !r_keep5, "point behind depth limit kept")
    `PFR_ASSERT_NXT(a_far_dropped, i_clk, i_rst_n, r_v4 && take5 && r_big4, !r_keep5, "out-of-range coordinate kept")
    `PFR_ASSERT_NXT(a_stage4_held, i_clk, i_rst_n, r_v4 && !take5, r_v4 && $stable(r_rhs4), "stalled request lost in stage 4")
    `PFR_ASSERT_NXT(a_stage5_filled, i_clk, i_rst_n, r_v4 && take5, r_v5, "request dropped between stages 4 and 5")

endmodule

### tb/sv/fov_crop_checker.sv
// Checker for point_fov_range_filter_core: mirrors the register file, predicts the keep
// flag of every accepted request and compares each accepted result in order.
// Depends on pfr_pkg.
module fov_crop_checker import pfr_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_valid,
    input  logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_world_x,
    input  logic signed [COORD_WIDTH-1:0] i_world_y,
    input  logic signed [COORD_WIDTH-1:0] i_world_z,
    input  logic                          i_frame_last,
    input  logic                          o_valid,
    input  logic                          i_ready,
    input  logic signed [COORD_WIDTH-1:0] o_out_x,
    input  logic signed [COORD_WIDTH-1:0] o_out_y,
    input  logic signed [COORD_WIDTH-1:0] o_out_z,
    input  logic                          o_keep,
    input  logic                          o_out_last,
    output int                            fail_count,
    output int                            pending,
    output int                            kept
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] RANGE_CAP = 64'd1 << (DIST_W / 2);
    localparam int          DUE_DEPTH = 16;

    typedef struct {
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
        logic [COORD_WIDTH-1:0] z;
        logic                   keep;
        logic                   last;
    } t_crop_result;

    logic signed [COORD_WIDTH-1:0] veh_pos [3];
    logic [ROT_ROW_W-1:0]          rot_rows [3];
    logic [TAN_W-1:0]              tan_lim;
    logic [DIST_W-1:0]             dist_lim;
    t_crop_result                  due_mem [DUE_DEPTH];
    logic [3:0]                    due_wr;
    logic [3:0]                    due_rd;
    int                            due_cnt;

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic in_view(
        input logic signed [COORD_WIDTH-1:0] wx,
        input logic signed [COORD_WIDTH-1:0] wy,
        input logic signed [COORD_WIDTH-1:0] wz
    );
        longint                        off [3];
        longint                        body [3];
        longint                        acc;
        logic signed [ROT_ENTRY_W-1:0] coef;
        logic [63:0]                   lat, span, ax, ay, az;
        off[0] = longint'(wx) - longint'(veh_pos[0]);
        off[1] = longint'(wy) - longint'(veh_pos[1]);
        off[2] = longint'(wz) - longint'(veh_pos[2]);
        for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) begin
                coef = rot_rows[r][k*ROT_ENTRY_W +: ROT_ENTRY_W];
                acc += longint'(coef) * off[k];
            end
            body[r] = acc >>> ROT_FRAC_BITS;
        end
        if (body[0] < DEPTH_MIN)
            return 1'b0;
        if (tan_lim != TAN_ALL_ONES) begin
            lat  = magnitude(body[1]) << TAN_FRAC_BITS;
            span = 64'(body[0]) * 64'(tan_lim);
            if (lat > span)
                return 1'b0;
        end
        ax = magnitude(body[0]);
        ay = magnitude(body[1]);
        az = magnitude(body[2]);
        if (ax >= RANGE_CAP || ay >= RANGE_CAP || az >= RANGE_CAP)
            return 1'b0;
        return (ax * ax + ay * ay + az * az) <= 64'(dist_lim);
    endfunction

    task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
        $display("%0t ns: %s expected %h, got %h", $time, field, want, got);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_crop_result want;
        if (!i_rst_n) begin
            veh_pos    = '{default: '0};
            rot_rows   = '{ROT_ROW0_RST, ROT_ROW1_RST, ROT_ROW2_RST};
            tan_lim    = TAN_RST;
            dist_lim   = DIST_RST;
            due_wr     = '0;
            due_rd     = '0;
            due_cnt    = 0;
            fail_count = 0;
            kept       = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_POS_X:    veh_pos[0]  = i_cfg_data[COORD_WIDTH-1:0];
                    CFG_POS_Y:    veh_pos[1]  = i_cfg_data[COORD_WIDTH-1:0];
                    CFG_POS_Z:    veh_pos[2]  = i_cfg_data[COORD_WIDTH-1:0];
                    CFG_ROT_ROW0: rot_rows[0] = i_cfg_data[ROT_ROW_W-1:0];
                    CFG_ROT_ROW1: rot_rows[1] = i_cfg_data[ROT_ROW_W-1:0];
                    CFG_ROT_ROW2: rot_rows[2] = i_cfg_data[ROT_ROW_W-1:0];
                    CFG_TAN:      tan_lim     = i_cfg_data[TAN_W-1:0];
                    CFG_MAX_DIST: dist_lim    = i_cfg_data[DIST_W-1:0];
                    default: ;
                endcase
            end
            if (o_valid && i_ready) begin
                if (due_cnt == 0) begin
                    $display("%0t ns: result with no request outstanding, x %h keep %b",
                             $time, o_out_x, o_keep);
                    fail_count++;
                end else begin
                    want   = due_mem[due_rd];
                    due_rd = due_rd + 1'b1;
                    due_cnt--;
                    if (want.keep)
                        kept++;
                    if (o_out_x !== want.x)       report("out_x", want.x, o_out_x);
                    if (o_out_y !== want.y)       report("out_y", want.y, o_out_y);
                    if (o_out_z !== want.z)       report("out_z", want.z, o_out_z);
                    if (o_keep !== want.keep)     report("keep", want.keep, o_keep);
                    if (o_out_last !== want.last) report("out_last", want.last, o_out_last);
                end
            end
            if (i_valid && o_ready) begin
                want.x    = i_world_x;
                want.y    = i_world_y;
                want.z    = i_world_z;
                want.keep = in_view(i_world_x, i_world_y, i_world_z);
                want.last = i_frame_last;
                if (due_cnt == DUE_DEPTH) begin
                    $display("%0t ns: more requests outstanding than the pipeline can hold",
                             $time);
                    fail_count++;
                end else begin
                    due_mem[due_wr] = want;
                    due_wr          = due_wr + 1'b1;
                    due_cnt++;
                end
            end
        end
        pending = due_cnt;
    end

endmodule

### tb/sv/tb.sv
// Top of the point_fov_range_filter_core bench: clock, reset, register phases and
// point stimulus with random gaps on both channels; the verdict comes from fov_crop_checker.
// Depends on pfr_pkg, fov_crop_checker and the block's RTL.
module tb import pfr_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                   RX_HOLD       = 80;
    localparam int                   PHASES        = 8;
    localparam int                   PHASE_POINTS  = 200;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO  = CFG_MAX_DIST + 1'b1;
    localparam logic [15:0]          Q14_ONE       = 16'h4000;
    localparam logic [15:0]          Q14_NEG_ONE   = 16'hC000;
    localparam logic [15:0]          Q14_COS45     = 16'd11585;
    localparam logic [15:0]          Q14_NEG_COS45 = 16'hD2BF;
    localparam logic [15:0]          Q14_MAX       = 16'h7FFF;
    localparam logic [15:0]          Q14_MIN       = 16'h8000;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index;
    logic [CFG_DATA_W-1:0]         i_cfg_data;
    logic                          i_valid;
    logic                          o_ready;
    logic signed [COORD_WIDTH-1:0] i_world_x;
    logic signed [COORD_WIDTH-1:0] i_world_y;
    logic signed [COORD_WIDTH-1:0] i_world_z;
    logic                          i_frame_last;
    logic                          o_valid;
    logic                          i_ready;
    logic signed [COORD_WIDTH-1:0] o_out_x;
    logic signed [COORD_WIDTH-1:0] o_out_y;
    logic signed [COORD_WIDTH-1:0] o_out_z;
    logic                          o_keep;
    logic                          o_out_last;
    int                            fail_count;
    int                            pending;
    int                            kept;

    logic                   stall_req;
    logic                   tx_steady;
    logic                   rx_steady;
    int                     sent;
    logic [COORD_WIDTH-1:0] cur_pos [3];

    point_fov_range_filter_core dut (.*);
    fov_crop_checker u_checker (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    function automatic logic [ROT_ROW_W-1:0] pack_row(input logic [15:0] ex, ey, ez);
        return {ez, ey, ex};
    endfunction

    function automatic logic [COORD_WIDTH-1:0] near_pos();
        return int'($urandom_range(0, 1 << 21)) - (1 << 20);
    endfunction

    function automatic logic [COORD_WIDTH-1:0] extreme_coord(input logic [COORD_WIDTH-1:0] p);
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return p;
            4:       return p + 1;
            default: return p + 51200;
        endcase
    endfunction

    // receiver: random back-pressure, or one long hold-off on request
    initial begin
        int   gap;
        logic held_off;
        gap      = 0;
        held_off = 1'b0;
        i_ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_req && !held_off) begin
                i_ready = 1'b0;
                repeat (RX_HOLD - 1) @(negedge i_clk);
                held_off = 1'b1;
            end else if (gap > 0) begin
                i_ready = 1'b0;
                gap--;
            end else begin
                i_ready = 1'b1;
                if (!rx_steady && $urandom_range(0, 3) == 0)
                    gap = idle_len();
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic offer_point(input logic [COORD_WIDTH-1:0] x, y, z, input logic last);
        int gap;
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      = 1'b1;
        i_world_x    = x;
        i_world_y    = y;
        i_world_z    = z;
        i_frame_last = last;
        do @(posedge i_clk); while (!o_ready);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic random_point();
        logic [COORD_WIDTH-1:0] pt [3];
        int                     off [3];
        int                     mode, span;
        mode = $urandom_range(0, 99);
        if (mode < 75) begin
            span = (mode < 55) ? 16 : 24;
            foreach (off[a])
                off[a] = int'($urandom_range(0, 2 << span)) - (1 << span);
            if ($urandom_range(0, 3) == 0) off[1] = 0;
            if ($urandom_range(0, 3) == 0) off[2] = 0;
            if ($urandom_range(0, 9) == 0) off[1] = $urandom_range(0, 1) ? off[0] : -off[0];
            foreach (pt[a])
                pt[a] = cur_pos[a] + off[a];
        end else if (mode < 88) begin
            foreach (pt[a])
                pt[a] = $urandom;
        end else begin
            foreach (pt[a])
                pt[a] = extreme_coord(cur_pos[a]);
        end
        offer_point(pt[0], pt[1], pt[2], $urandom_range(0, 15) == 0);
    endtask

    task automatic set_config(input int phase);
        logic [COORD_WIDTH-1:0] pos [3];
        logic [ROT_ROW_W-1:0]   rows [3];
        logic [TAN_W-1:0]       tn;
        logic [DIST_W-1:0]      dd;
        foreach (pos[a])
            pos[a] = near_pos();
        rows = '{ROT_ROW0_RST, ROT_ROW1_RST, ROT_ROW2_RST};
        tn   = TAN_RST;
        dd   = DIST_RST;
        case (phase)
            1: begin
                pos = '{default: '0};
                tn  = TAN_ALL_ONES;
                dd  = '1;
            end
            2: begin
                tn = '0;
                dd = rand48() >> $urandom_range(8, 20);
            end
            3: begin
                if ($urandom_range(0, 1))
                    rows = '{pack_row('0, Q14_ONE, '0), pack_row(Q14_NEG_ONE, '0, '0),
                             pack_row('0, '0, Q14_ONE)};
                else
                    rows = '{pack_row(Q14_COS45, Q14_COS45, '0),
                             pack_row(Q14_NEG_COS45, Q14_COS45, '0),
                             pack_row('0, '0, Q14_ONE)};
                tn = TAN_W'($urandom);
            end
            4: begin
                foreach (pos[a])
                    pos[a] = $urandom;
                foreach (rows[r])
                    rows[r] = rand48();
                tn = TAN_W'($urandom);
                dd = rand48() >> $urandom_range(0, 12);
            end
            5: begin
                pos  = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
                rows = '{pack_row(Q14_MAX, Q14_MIN, Q14_MAX),
                         pack_row(Q14_MIN, Q14_MIN, Q14_MIN),
                         pack_row(Q14_MAX, Q14_MAX, Q14_MAX)};
                tn   = TAN_ALL_ONES;
                dd   = '1;
            end
            6: begin
                tn = TAN_W'($urandom);
                dd = '0;
            end
            7: begin
                rows = '{pack_row(Q14_COS45, Q14_NEG_COS45, '0),
                         pack_row(Q14_COS45, Q14_COS45, '0),
                         pack_row('0, '0, Q14_ONE)};
                tn   = TAN_W'($urandom_range(32'h8000, 32'h3_0000));
                dd   = rand48() >> $urandom_range(14, 22);
            end
            default: ;
        endcase
        write_reg(CFG_POS_X, {16'($urandom), pos[0]});
        write_reg(CFG_POS_Y, {16'($urandom), pos[1]});
        write_reg(CFG_POS_Z, {16'($urandom), pos[2]});
        write_reg(CFG_ROT_ROW0, rows[0]);
        write_reg(CFG_ROT_ROW1, rows[1]);
        write_reg(CFG_ROT_ROW2, rows[2]);
        write_reg(CFG_TAN, {24'($urandom), tn});
        write_reg(CFG_MAX_DIST, dd);
        // unmapped index last, so any aliasing onto a live register shows up
        write_reg(CFG_SPARE_LO + CFG_IDX_W'($urandom_range(0, 7)), rand48());
        cur_pos = pos;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_world_x    = '0;
        i_world_y    = '0;
        i_world_z    = '0;
        i_frame_last = 1'b0;
        stall_req    = 1'b0;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        sent         = 0;
        cur_pos      = '{default: '0};
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: depth, cone edge, range edge, far points, extremes
        offer_point(0, 0, 0, 1'b0);
        offer_point(1, 0, 0, 1'b1);
        offer_point(-1, 0, 0, 1'b0);
        offer_point(1024, 1024, 0, 1'b0);
        offer_point(1024, -1024, 7, 1'b0);
        offer_point(1024, 1025, 0, 1'b0);
        offer_point(1024, -1025, 0, 1'b1);
        offer_point(51200, 0, 0, 1'b0);
        offer_point(51201, 0, 0, 1'b0);
        offer_point(1 << 24, 0, 0, 1'b0);
        offer_point((1 << 24) - 1, 0, 0, 1'b0);
        offer_point(30000, 0, 40000, 1'b0);
        offer_point(30000, 0, 41000, 1'b0);
        offer_point(30000, 0, 42000, 1'b0);
        offer_point(100, 0, -51000, 1'b1);
        offer_point(0, 5, 5, 1'b0);
        offer_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        offer_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        offer_point(32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b1);
        offer_point(-1, -1, -1, 1'b0);
        offer_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
        offer_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            set_config(phase);
            rx_steady = (phase == 1 || phase == 5);
            for (int n = 0; n < PHASE_POINTS; n++) begin
                tx_steady = (n >= 120 && n < 160) || (phase == 2 && n >= 40 && n < 100);
                if (phase == 2 && n == 40)
                    stall_req = 1'b1;
                if (phase == 4 && n == 100)
                    drain();
                random_point();
            end
            drain();
        end

        repeat (20) @(negedge i_clk);
        $display("Sent %0d points through %0d register settings, %0d kept.", sent, PHASES + 1,
                 kept);
        $display("Covered identity, yaw and arbitrary rotations, zero to open cones, zero to full range.");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
